// ===== sv/ipacl_pkg.sv =====
package ipacl_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int SLOT_W     = 4;
    localparam int PREFIX_W   = 8;
    localparam int HALF_W     = 64;
    localparam int V4_BITS    = 32;
    localparam int V6_BITS    = 128;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 8;

    localparam logic [31:0] MAPPED_TAG = 32'h0000_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                store;
        logic                is_v6;
        logic [PREFIX_W-1:0] prefix_len;
        logic [HALF_W-1:0]   addr_high;
        logic [HALF_W-1:0]   addr_low;
    } t_wr;

    typedef struct packed {
        logic              use_v4;
        logic [HALF_W-1:0] addr_high;
        logic [HALF_W-1:0] addr_low;
    } t_query;

    typedef struct packed {
        logic              run;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_scan;

    function automatic logic [31:0] f_v4_mask(input logic [PREFIX_W-1:0] p);
        logic [31:0] m;
        m = '0;
        if (p != '0 && p <= PREFIX_W'(V4_BITS)) begin
            m = 32'hFFFF_FFFF << (6'd32 - p[5:0]);
        end
        return m;
    endfunction

    function automatic logic [127:0] f_v6_mask(input logic [PREFIX_W-1:0] p);
        logic [127:0] m;
        m = '0;
        if (p != '0 && p <= PREFIX_W'(V6_BITS)) begin
            m = {128{1'b1}} << (8'd128 - p);
        end
        return m;
    endfunction

endpackage

// ===== sv/ip_prefix_acl_match.sv =====
// Write transfer: result registered at acceptance, table updated at that same edge.
// Query transfer: the query is registered and a token walks the row of slot cells
// one cell per cycle; the result is registered once the token leaves the last cell.
// One item is in flight at a time; a query holds the block until its scan ends.
// Synchronous active-low reset empties the table and drops any pending result.
module ip_prefix_acl_match
    import ipacl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // slot[3:0], enable[4], is_v6[5], prefix_len[13:6], addr_high[77:14],
    // addr_low[141:78], zero[143:142]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // matched[0], match_slot[4:1], rejected[5], zero[7:6]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              r_state;
    logic              r_start;
    t_query            r_query;
    logic              r_out_valid;
    logic              r_matched;
    logic [SLOT_W-1:0] r_match_slot;
    logic              r_rejected;

    logic                w_accept;
    logic                w_is_write;
    logic [SLOT_W-1:0]   w_slot;
    logic                w_enable;
    logic                w_is_v6;
    logic [PREFIX_W-1:0] w_prefix;
    logic [HALF_W-1:0]   w_high;
    logic [HALF_W-1:0]   w_low;
    logic                w_bad;
    logic                w_mapped;
    t_wr                 w_wr;
    t_scan               w_chain [0:SLOTS];

    assign w_slot   = i_s_axis_tdata[3:0];
    assign w_enable = i_s_axis_tdata[4];
    assign w_is_v6  = i_s_axis_tdata[5];
    assign w_prefix = i_s_axis_tdata[13:6];
    assign w_high   = i_s_axis_tdata[77:14];
    assign w_low    = i_s_axis_tdata[141:78];

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_write      = (i_s_axis_tuser == OP_WRITE);

    assign w_bad    = w_enable && !w_is_v6 && (w_prefix > PREFIX_W'(V4_BITS));
    assign w_mapped = w_is_v6 && (w_high == '0) && (w_low[63:32] == MAPPED_TAG);

    always_comb begin
        w_wr.store      = w_enable && !w_bad;
        w_wr.is_v6      = w_is_v6;
        w_wr.prefix_len = w_prefix;
        w_wr.addr_high  = w_high;
        w_wr.addr_low   = w_low;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_write) begin
            r_query.use_v4    <= !w_is_v6 || w_mapped;
            r_query.addr_high <= w_high;
            r_query.addr_low  <= w_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= w_accept && !w_is_write;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && !w_is_write) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_chain[SLOTS].run) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign w_chain[0] = '{run: r_start, found: 1'b0, slot: '0};

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            logic w_sel;
            assign w_sel = w_accept && w_is_write && (32'(w_slot) == gi);
            ipacl_cell #(
                .INDEX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wr_sel(w_sel),
                .i_wr    (w_wr),
                .i_query (r_query),
                .i_scan  (w_chain[gi]),
                .o_scan  (w_chain[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_chain[SLOTS].run || (w_accept && w_is_write)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chain[SLOTS].run) begin
            r_matched    <= w_chain[SLOTS].found;
            r_match_slot <= w_chain[SLOTS].found ? w_chain[SLOTS].slot : '0;
            r_rejected   <= 1'b0;
        end else if (w_accept && w_is_write) begin
            r_matched    <= 1'b0;
            r_match_slot <= '0;
            r_rejected   <= w_bad;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_rejected, r_match_slot, r_matched};

endmodule

// ===== sv/ipacl_cell.sv =====
module ipacl_cell
    import ipacl_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_sel,
    input  t_wr    i_wr,
    input  t_query i_query,
    input  t_scan  i_scan,
    output t_scan  o_scan
);

    logic              r_valid;
    logic              r_family;
    logic              r_never;
    logic [HALF_W-1:0] r_mask_high;
    logic [HALF_W-1:0] r_mask_low;
    logic [HALF_W-1:0] r_high;
    logic [HALF_W-1:0] r_low;
    t_scan             r_scan;

    logic [127:0] w_v6_mask;
    logic [31:0]  w_v4_mask;
    logic         w_v4_hit;
    logic         w_v6_hit;
    logic         w_hit;
    t_scan        n_scan;

    assign w_v6_mask = f_v6_mask(i_wr.prefix_len);
    assign w_v4_mask = f_v4_mask(i_wr.prefix_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_sel) begin
            r_valid <= i_wr.store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_sel && i_wr.store) begin
            r_family <= i_wr.is_v6;
            r_never  <= i_wr.is_v6 && (i_wr.prefix_len > PREFIX_W'(V6_BITS));
            if (i_wr.is_v6) begin
                r_mask_high <= w_v6_mask[127:64];
                r_mask_low  <= w_v6_mask[63:0];
                r_high      <= i_wr.addr_high;
                r_low       <= i_wr.addr_low;
            end else begin
                r_mask_high <= '0;
                r_mask_low  <= {32'b0, w_v4_mask};
                r_high      <= '0;
                r_low       <= {32'b0, i_wr.addr_low[31:0] & w_v4_mask};
            end
        end
    end

    always_comb begin
        w_v4_hit = !r_family && i_query.use_v4 &&
                   ((i_query.addr_low[31:0] & r_mask_low[31:0]) == r_low[31:0]);
        w_v6_hit = r_family && !i_query.use_v4 && !r_never &&
                   (((i_query.addr_high ^ r_high) & r_mask_high) == '0) &&
                   (((i_query.addr_low ^ r_low) & r_mask_low) == '0);
        w_hit = r_valid && (w_v4_hit || w_v6_hit);
        n_scan.run   = i_scan.run;
        n_scan.found = i_scan.found || (i_scan.run && w_hit);
        n_scan.slot  = i_scan.found ? i_scan.slot : SLOT_W'(INDEX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== tb/tb.sv =====
module tb;
    import ipacl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic                en;
        logic                v6;
        logic [PREFIX_W-1:0] plen;
        logic [HALF_W-1:0]   ah;
        logic [HALF_W-1:0]   al;
    } acl_item_t;

    typedef struct packed {
        logic              matched;
        logic [SLOT_W-1:0] slot;
        logic              rejected;
    } acl_result_t;

    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SIZE   = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    acl_item_t   xfer_q[$];
    acl_result_t verdict_q[$];
    acl_item_t   offered = '0;

    logic                tab_used[SLOTS_DEF];
    logic                tab_v6[SLOTS_DEF];
    logic [PREFIX_W-1:0] tab_len[SLOTS_DEF];
    logic [HALF_W-1:0]   tab_hi[SLOTS_DEF];
    logic [HALF_W-1:0]   tab_lo[SLOTS_DEF];

    logic [HALF_W-1:0] pool_hi[POOL_SIZE];
    logic [HALF_W-1:0] pool_lo[POOL_SIZE];

    int src_idle = 0;
    int snk_idle = 0;
    int bad_count = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cnt = 0;

    ip_prefix_acl_match uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [HALF_W-1:0] net4_mask(input int p);
        return (64'hFFFF_FFFF << (32 - p)) & 64'hFFFF_FFFF;
    endfunction

    function automatic logic [HALF_W-1:0] hi_mask(input int n);
        if (n == 0) begin
            return '0;
        end
        return ~64'd0 << (64 - n);
    endfunction

    function automatic logic prefix6_hit(input int p, input logic [HALF_W-1:0] qh,
                                         input logic [HALF_W-1:0] ql,
                                         input logic [HALF_W-1:0] eh,
                                         input logic [HALF_W-1:0] el);
        if (p > V6_BITS) begin
            return 1'b0;
        end
        if (p <= HALF_W) begin
            return ((qh ^ eh) & hi_mask(p)) == '0;
        end
        if (qh != eh) begin
            return 1'b0;
        end
        return ((ql ^ el) & hi_mask(p - HALF_W)) == '0;
    endfunction

    // Applies one accepted transfer to the shadow table and returns its verdict.
    function automatic acl_result_t acl_step(input acl_item_t it);
        acl_result_t r;
        logic        bad;
        logic        by_v4;
        logic        hit;
        int          p;
        r = '0;
        if (it.op == OP_WRITE) begin
            bad = it.en && !it.v6 && (it.plen > V4_BITS);
            r.rejected = bad;
            if (!it.en || bad) begin
                tab_used[it.slot] = 1'b0;
            end else begin
                tab_used[it.slot] = 1'b1;
                tab_v6[it.slot] = it.v6;
                tab_len[it.slot] = it.plen;
                tab_hi[it.slot] = it.v6 ? it.ah : '0;
                tab_lo[it.slot] = it.v6 ? it.al : (it.al & net4_mask(int'(it.plen)));
            end
        end else begin
            by_v4 = !it.v6 || (it.ah == '0 && it.al[63:32] == MAPPED_TAG);
            for (int i = 0; i < SLOTS_DEF; i++) begin
                if (!r.matched && tab_used[i]) begin
                    hit = 1'b0;
                    if (!tab_v6[i]) begin
                        p = (tab_len[i] > V4_BITS) ? V4_BITS : int'(tab_len[i]);
                        if (by_v4) begin
                            hit = ({32'd0, it.al[31:0]} & net4_mask(p)) == tab_lo[i];
                        end
                    end else if (!by_v4) begin
                        hit = prefix6_hit(int'(tab_len[i]), it.ah, it.al,
                                          tab_hi[i], tab_lo[i]);
                    end
                    if (hit) begin
                        r.matched = 1'b1;
                        r.slot = SLOT_W'(i);
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic acl_item_t mk(input logic op, input int slot, input int en,
                                     input int v6, input int plen,
                                     input logic [HALF_W-1:0] ah,
                                     input logic [HALF_W-1:0] al);
        acl_item_t it;
        it.op = op;
        it.slot = SLOT_W'(slot);
        it.en = 1'(en);
        it.v6 = 1'(v6);
        it.plen = PREFIX_W'(plen);
        it.ah = ah;
        it.al = al;
        return it;
    endfunction

    function automatic acl_item_t rand_item();
        acl_item_t    it;
        int           k;
        int           kind;
        logic [127:0] addr;
        logic [31:0]  v4;
        k = $urandom_range(0, POOL_SIZE - 1);
        addr = {pool_hi[k], pool_lo[k]};
        if ($urandom_range(0, 2) != 0) begin
            addr = addr ^ (128'd1 << $urandom_range(0, 127));
        end
        v4 = pool_lo[k][31:0];
        if ($urandom_range(0, 1) != 0) begin
            v4 = v4 ^ (32'd1 << $urandom_range(0, 31));
        end
        it.slot = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
        it.en = ($urandom_range(0, 9) != 0);
        it.ah = {$urandom, $urandom};
        it.al = {$urandom, v4};
        it.plen = '0;
        if ($urandom_range(0, 1) == 0) begin
            it.op = OP_WRITE;
            it.v6 = 1'($urandom_range(0, 1));
            if (it.v6) begin
                it.ah = pool_hi[k];
                it.al = pool_lo[k];
                it.plen = ($urandom_range(0, 11) == 0) ? PREFIX_W'($urandom_range(129, 255))
                                                       : PREFIX_W'($urandom_range(0, 128));
            end else begin
                it.plen = ($urandom_range(0, 9) == 0) ? PREFIX_W'($urandom_range(33, 255))
                                                      : PREFIX_W'($urandom_range(0, 32));
            end
        end else begin
            it.op = OP_QUERY;
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                it.v6 = 1'b0;
            end else if (kind < 11) begin
                it.v6 = 1'b1;
                it.ah = '0;
                it.al = {MAPPED_TAG, v4};
            end else begin
                it.v6 = 1'b1;
                it.ah = addr[127:64];
                it.al = addr[63:0];
            end
            if ($urandom_range(0, 3) == 0) begin
                it.plen = PREFIX_W'($urandom_range(0, 255));
            end
        end
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                verdict_q.push_back(acl_step(offered));
            end
            if (xfer_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
                offered <= xfer_q[0];
                s_tdata <= {2'b00, xfer_q[0].al, xfer_q[0].ah, xfer_q[0].plen,
                            xfer_q[0].v6, xfer_q[0].en, xfer_q[0].slot};
                s_tuser <= xfer_q[0].op;
                s_tvalid <= 1'b1;
                xfer_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        acl_result_t got;
        acl_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.matched = m_tdata[0];
            got.slot = m_tdata[4:1];
            got.rejected = m_tdata[5];
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result matched=%0d slot=%0d rejected=%0d",
                         $time, got.matched, got.slot, got.rejected);
                bad_count++;
            end else begin
                want = verdict_q.pop_front();
                if (got.matched !== want.matched || got.slot !== want.slot ||
                    got.rejected !== want.rejected) begin
                    $display("%0t: expected matched=%0d slot=%0d rejected=%0d, %s%0d %0d %0d",
                             $time, want.matched, want.slot, want.rejected,
                             "actual ", got.matched, got.slot, got.rejected);
                    bad_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (xfer_q.size() != 0 || s_tvalid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int n, input int src, input int snk, input logic hold);
        src_idle = src;
        snk_idle = snk;
        hold_req = hold;
        for (int i = 0; i < n; i++) begin
            xfer_q.push_back(rand_item());
        end
        wait_drained();
    endtask

    initial begin
        #5000000;
        $display("ip_prefix_acl_match: mismatch");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
            tab_used[i] = 1'b0;
            tab_v6[i] = 1'b0;
            tab_len[i] = '0;
            tab_hi[i] = '0;
            tab_lo[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[0] = '0;
        pool_lo[0] = {MAPPED_TAG, $urandom};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        xfer_q.push_back(mk(OP_QUERY, 0, 1, 0, 0, '0, 64'hC0A8_0001));
        xfer_q.push_back(mk(OP_QUERY, 0, 1, 1, 0, {64{1'b1}}, {64{1'b1}}));
        xfer_q.push_back(mk(OP_WRITE, 15, 1, 0, 32, {64{1'b1}}, {64{1'b1}}));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, {64{1'b1}}, 64'hFFFF_FFFF));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, '0, {MAPPED_TAG, 32'hFFFF_FFFF}));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, '0, {32'h0001_FFFF, 32'hFFFF_FFFF}));
        xfer_q.push_back(mk(OP_WRITE, 3, 1, 0, 33, '0, 64'h0A00_0000));
        xfer_q.push_back(mk(OP_WRITE, 3, 1, 0, 255, '0, 64'h0A00_0000));
        xfer_q.push_back(mk(OP_WRITE, 3, 0, 0, 255, '0, 64'h0A00_0000));
        xfer_q.push_back(mk(OP_WRITE, 1, 1, 1, 0, 64'h2001_0DB8_0000_0000, '0));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, 64'h1234_5678_9ABC_DEF0, 64'h1));
        xfer_q.push_back(mk(OP_WRITE, 0, 1, 1, 128, {64{1'b1}}, {64{1'b1}}));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, {64{1'b1}}, {64{1'b1}}));
        xfer_q.push_back(mk(OP_WRITE, 1, 0, 1, 0, '0, '0));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, {64{1'b1}}, {{63{1'b1}}, 1'b0}));
        xfer_q.push_back(mk(OP_WRITE, 2, 1, 1, 200, 64'hFE80_0000_0000_0000, 64'h5));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, 64'hFE80_0000_0000_0000, 64'h5));
        xfer_q.push_back(mk(OP_WRITE, 4, 1, 1, 64, 64'hFE80_0000_0000_0000, 64'h7));
        xfer_q.push_back(mk(OP_WRITE, 6, 1, 1, 65, 64'hFD00_0000_0000_0001, '0));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, 64'hFE80_0000_0000_0000, 64'h9));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, 64'hFD00_0000_0000_0001,
                            64'h7FFF_FFFF_FFFF_FFFF));
        xfer_q.push_back(mk(OP_WRITE, 5, 1, 0, 0, '0, 64'hDEAD_BEEF));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 0, 0, '0, '0));
        xfer_q.push_back(mk(OP_WRITE, 9, 1, 0, 24, {64{1'b1}}, 64'hFFFF_FFFF_0A01_02FF));
        xfer_q.push_back(mk(OP_QUERY, 0, 0, 1, 0, '0, {MAPPED_TAG, 32'h0A01_0203}));
        wait_drained();

        run_phase(610, 28, 60, 1'b0);
        run_phase(610, 60, 28, 1'b0);
        run_phase(605, 0, 0, 1'b1);

        repeat (40) @(posedge i_clk);
        if (bad_count == 0 && verdict_q.size() == 0 && xfer_q.size() == 0) begin
            $display("ip_prefix_acl_match: match");
        end else begin
            $display("ip_prefix_acl_match: mismatch");
        end
        $finish;
    end

endmodule

// ===== ip_prefix_acl_match.f =====
sv/ipacl_pkg.sv
sv/ipacl_cell.sv
sv/ip_prefix_acl_match.sv
tb/tb.sv
